### design/quoted_token_splitter_unit_defines.svh
// Assertion macros used by the quoted token splitter datapath.
`ifndef QUOTED_TOKEN_SPLITTER_UNIT_DEFINES_SVH
`define QUOTED_TOKEN_SPLITTER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// A property checked at every rising clock edge outside reset.
`define QTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition that must never hold outside reset.
`define QTS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define QTS_ASSERT(lbl, prop, msg)
`define QTS_NEVER(lbl, cond, msg)
`endif

`endif

### design/qts_pkg.sv
// Shared types, constants and helper function of the quoted token splitter.
`default_nettype none

package qts_pkg;

  // Sizes of the prefix buffer, the character sets and the per-word result limit.
  localparam int PREFIX_DEPTH = 8;
  localparam int SET_SLOTS    = 8;
  localparam int MAX_RESULTS  = 9;

  localparam int CH_W    = 8;
  localparam int CFG_W   = 64;
  localparam int CNT_REG_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W   = $clog2(PREFIX_DEPTH + 1);
  localparam int IDX_W   = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);

  // Special characters.
  localparam logic [CH_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [CH_W-1:0] CH_BACKSLASH = 8'h5C;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNTERM   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_CHARS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD_CHARS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD_COUNT = 2'd3;

  // Processing phase commanded by the controller.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CHAR,
    PH_FLUSH,
    PH_LAST
  } phase_t;

  // Status reported by the datapath to the controller.
  typedef struct packed {
    logic accept;
    logic need_flush;
    logic flush_done;
    logic blocked;
    logic item_last;
  } qts_stat_t;

  // One result word.
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            valid;
    logic            tend;
    logic [1:0]      status;
    logic            halt;
  } result_t;

  // True when c matches one of the first count byte slots.
  function automatic logic in_set(input logic [CFG_W-1:0] slots,
                                  input logic [CNT_REG_W-1:0] count,
                                  input logic [CH_W-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SET_SLOTS; i++) begin
      if ((CNT_REG_W'(i) < count) && (slots[CH_W*i +: CH_W] == c)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

### design/qts_if.sv
// Handshake channels of the quoted token splitter: character input and result output.
`default_nettype none

interface qts_in_if;
  import qts_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            has_char;
  logic            last;

  modport source (output valid, output ch, output has_char, output last, input ready);
  modport sink (input valid, input ch, input has_char, input last, output ready);
endinterface

interface qts_out_if;
  import qts_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_ch;
  logic            out_valid;
  logic            token_end;
  logic [1:0]      status;
  logic            halted;
  logic            run_last;

  modport source (output valid, output out_ch, output out_valid, output token_end,
                  output status, output halted, output run_last, input ready);
  modport sink (input valid, input out_ch, input out_valid, input token_end,
                input status, input halted, input run_last, output ready);
endinterface

`default_nettype wire

### design/qts_ctrl.sv
// Phase sequencer of the quoted token splitter.
`default_nettype none

module qts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  qts_pkg::qts_stat_t stat,
  output qts_pkg::phase_t    phase
);
  import qts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHAR,
    S_FLUSH,
    S_LAST
  } state_t;

  state_t state;
  logic   ret_last;

  // Walk each word through its character phase, any prefix flush and, when last is set, its end phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_IDLE;
      ret_last <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (stat.accept) begin
            state <= S_CHAR;
            phase <= PH_CHAR;
          end
        end
        S_CHAR: begin
          if (stat.need_flush) begin
            state    <= S_FLUSH;
            phase    <= PH_FLUSH;
            ret_last <= 1'b0;
          end else if (!stat.blocked) begin
            if (stat.item_last) begin
              state <= S_LAST;
              phase <= PH_LAST;
            end else begin
              state <= S_IDLE;
              phase <= PH_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (!stat.blocked && stat.flush_done) begin
            if (ret_last) begin
              state <= S_LAST;
              phase <= PH_LAST;
            end else begin
              state <= S_CHAR;
              phase <= PH_CHAR;
            end
          end
        end
        S_LAST: begin
          if (stat.need_flush) begin
            state    <= S_FLUSH;
            phase    <= PH_FLUSH;
            ret_last <= 1'b1;
          end else if (!stat.blocked) begin
            state <= S_IDLE;
            phase <= PH_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/qts_dp.sv
// Datapath of the quoted token splitter: config, parse mode, prefix buffer, result staging.
`default_nettype none
`include "quoted_token_splitter_unit_defines.svh"

module qts_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [qts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qts_pkg::CFG_W-1:0]       cfg_data,
  input  qts_pkg::phase_t                 phase,
  output qts_pkg::qts_stat_t              stat,
  qts_in_if.sink                          chars,
  qts_out_if.source                       tokens
);
  import qts_pkg::*;

  typedef enum logic [2:0] {
    M_START,
    M_PLAIN,
    M_QUOTED,
    M_ESCAPE,
    M_AFTER,
    M_HALTED
  } mode_t;

  // Configuration registers.
  logic [CFG_W-1:0]     delim_chars;
  logic [CNT_REG_W-1:0] delim_count;
  logic [CFG_W-1:0]     discard_chars;
  logic [CNT_REG_W-1:0] discard_count;

  // Parser state and the held prefix.
  mode_t           mode;
  mode_t           mode_next;
  logic [CH_W-1:0] prefix_buf [PREFIX_DEPTH];
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             buf_we;

  // The word being worked on.
  logic [CH_W-1:0] it_ch;
  logic            it_has;
  logic            it_last;
  logic            it_disc;
  logic            it_dlm;
  logic [CH_W-1:0] held_ch;
  logic            held_dlm;

  // Result staging: the newest result waits here until no later end can fold into it.
  result_t          pend;
  logic             pend_v;
  logic [RES_W-1:0] res_n;
  result_t          out_q;
  logic             out_v;
  logic             out_last;

  logic    op_put;
  logic    op_end;
  result_t put_res;
  result_t new_res;
  logic    need_flush;
  logic    flush_done;
  logic    fold;
  logic    create;
  logic    full;
  logic    push_op;
  logic    blocked;
  logic    can_push;
  logic    fin_push;
  logic    accept;

  assign it_disc  = in_set(discard_chars, discard_count, it_ch);
  assign it_dlm   = in_set(delim_chars, delim_count, it_ch);
  assign held_ch  = prefix_buf[idx];
  assign held_dlm = in_set(delim_chars, delim_count, held_ch);

  // Decode the operation of this cycle from phase, mode and the current character.
  always_comb begin
    op_put     = 1'b0;
    op_end     = 1'b0;
    put_res    = '0;
    mode_next  = mode;
    cnt_next   = cnt;
    idx_next   = idx;
    buf_we     = 1'b0;
    need_flush = 1'b0;
    flush_done = 1'b0;
    unique case (phase)
      PH_CHAR: begin
        if (it_has) begin
          unique case (mode) inside
            M_START: begin
              if (it_disc) begin
                if (cnt < CNT_W'(PREFIX_DEPTH)) begin
                  buf_we   = 1'b1;
                  cnt_next = cnt + CNT_W'(1);
                end else begin
                  op_put         = 1'b1;
                  put_res.status = ST_OVERFLOW;
                end
              end else if (it_ch == CH_QUOTE) begin
                cnt_next  = '0;
                mode_next = M_QUOTED;
              end else if (cnt != '0) begin
                need_flush = 1'b1;
              end else if (it_dlm) begin
                op_end = 1'b1;
              end else begin
                op_put        = 1'b1;
                put_res.ch    = it_ch;
                put_res.valid = 1'b1;
                mode_next     = M_PLAIN;
              end
            end
            M_PLAIN: begin
              if (it_dlm) begin
                op_end    = 1'b1;
                mode_next = M_START;
              end else begin
                op_put        = 1'b1;
                put_res.ch    = it_ch;
                put_res.valid = 1'b1;
              end
            end
            M_QUOTED: begin
              if (it_ch == CH_BACKSLASH) begin
                mode_next = M_ESCAPE;
              end else if (it_ch == CH_QUOTE) begin
                op_end    = 1'b1;
                mode_next = M_AFTER;
              end else begin
                op_put        = 1'b1;
                put_res.ch    = it_ch;
                put_res.valid = 1'b1;
              end
            end
            M_ESCAPE: begin
              op_put        = 1'b1;
              put_res.ch    = it_ch;
              put_res.valid = 1'b1;
              mode_next     = M_QUOTED;
            end
            M_AFTER: begin
              if (it_disc) begin
                mode_next = M_AFTER;
              end else if (it_dlm) begin
                mode_next = M_START;
              end else begin
                op_put       = 1'b1;
                put_res.halt = 1'b1;
                mode_next    = M_HALTED;
              end
            end
            default: begin
              mode_next = mode;
            end
          endcase
        end
      end
      PH_FLUSH: begin
        // A held delimiter splits the token; anything else is token text.
        if (held_dlm) begin
          op_end = 1'b1;
        end else begin
          op_put        = 1'b1;
          put_res.ch    = held_ch;
          put_res.valid = 1'b1;
        end
        if ((CNT_W'(idx) + CNT_W'(1)) == cnt) begin
          flush_done = 1'b1;
          cnt_next   = '0;
          idx_next   = '0;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      PH_LAST: begin
        if ((mode == M_START) && (cnt != '0)) begin
          need_flush = 1'b1;
        end else begin
          unique case (mode) inside
            M_START, M_PLAIN: begin
              op_end = 1'b1;
            end
            M_QUOTED, M_ESCAPE: begin
              op_put         = 1'b1;
              put_res.tend   = 1'b1;
              put_res.status = ST_UNTERM;
            end
            default: begin
              op_put = 1'b0;
            end
          endcase
          mode_next = M_START;
          cnt_next  = '0;
        end
      end
      default: begin
        op_put = 1'b0;
      end
    endcase
  end

  // Fold a token end into the staged result where allowed, else make a new result.
  always_comb begin
    new_res      = '0;
    new_res.tend = 1'b1;
    if (op_put) begin
      new_res = put_res;
    end
  end

  assign fold     = pend_v && pend.valid && !pend.tend && (pend.status == ST_OK);
  assign create   = op_put || (op_end && !fold);
  assign full     = (res_n >= RES_W'(MAX_RESULTS));
  assign can_push = !out_v || tokens.ready;
  assign push_op  = create && pend_v && !full;
  assign blocked  = push_op && !can_push;
  assign fin_push = (phase == PH_IDLE) && pend_v && can_push;

  assign chars.ready = !rst && (phase == PH_IDLE) && (!pend_v || can_push);
  assign accept      = chars.valid && chars.ready;

  assign stat.accept     = accept;
  assign stat.need_flush = need_flush;
  assign stat.flush_done = flush_done;
  assign stat.blocked    = blocked;
  assign stat.item_last  = it_last;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_chars   <= '0;
      delim_count   <= CNT_REG_W'(1);
      discard_chars <= '0;
      discard_count <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELIM_CHARS:   delim_chars   <= cfg_data;
        REG_DELIM_COUNT:   delim_count   <= cfg_data[CNT_REG_W-1:0];
        REG_DISCARD_CHARS: discard_chars <= cfg_data;
        REG_DISCARD_COUNT: discard_count <= cfg_data[CNT_REG_W-1:0];
        default: delim_count <= delim_count;
      endcase
    end
  end

  // Latch the accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      it_ch   <= chars.ch;
      it_has  <= chars.has_char;
      it_last <= chars.last;
    end
  end

  // Prefix buffer contents.
  always_ff @(posedge clk) begin
    if (buf_we && !blocked) begin
      prefix_buf[cnt[IDX_W-1:0]] <= it_ch;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_START;
      cnt  <= '0;
      idx  <= '0;
    end else if (!blocked) begin
      mode <= mode_next;
      cnt  <= cnt_next;
      idx  <= idx_next;
    end
  end

  // Staged result and per-word result count.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      res_n  <= '0;
    end else begin
      if (fin_push) begin
        pend_v <= 1'b0;
      end
      if (accept) begin
        res_n <= '0;
      end else if (!blocked) begin
        if (create) begin
          if (full) begin
            pend.status <= ST_OVERFLOW;
          end else begin
            pend   <= new_res;
            pend_v <= 1'b1;
            res_n  <= res_n + RES_W'(1);
          end
        end else if (op_end) begin
          pend.tend <= 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if ((push_op && !blocked) || fin_push) begin
      out_v    <= 1'b1;
      out_q    <= pend;
      out_last <= fin_push;
    end else if (tokens.ready) begin
      out_v <= 1'b0;
    end
  end

  assign tokens.valid     = out_v;
  assign tokens.out_ch    = out_q.ch;
  assign tokens.out_valid = out_q.valid;
  assign tokens.token_end = out_q.tend;
  assign tokens.status    = out_q.status;
  assign tokens.halted    = out_q.halt;
  assign tokens.run_last  = out_last;

  `QTS_NEVER(a_res_cap, res_n > RES_W'(MAX_RESULTS), "result count above limit")
  `QTS_NEVER(a_cnt_cap, cnt > CNT_W'(PREFIX_DEPTH), "prefix count above depth")
  `QTS_ASSERT(a_no_overrun, (out_v && !tokens.ready) |-> !(push_op && !blocked), "output overrun")
  `QTS_ASSERT(a_accept_seq, accept |=> (phase == PH_CHAR), "accepted word not processed")
  `QTS_ASSERT(a_flush_ctx, (phase == PH_FLUSH) |-> (mode == M_START && cnt != '0), "bad flush")

endmodule

`default_nettype wire

### design/quoted_token_splitter_unit.sv
// A word is accepted in the idle phase, then decoded in the character phase; when last is
// set it also runs the end phase. A prefix flush handles the held characters in turn, then
// reruns the interrupted phase. A stalled output holds the sequencer; a word's final result
// enters the output register in the idle phase after its last phase, once output can take
// it. Words are accepted only in the idle phase. Reset (rst, synchronous): parser to token
// start, prefix count and output cleared, config reset; prefix buffer undefined until written.
`default_nettype none

module quoted_token_splitter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [qts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qts_pkg::CFG_W-1:0]     cfg_data,
  qts_in_if.sink                        chars,
  qts_out_if.source                     tokens
);
  import qts_pkg::*;

  phase_t    phase;
  qts_stat_t stat;

  // Phase sequencer.
  qts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .stat  (stat),
    .phase (phase)
  );

  // Parser datapath and output register.
  qts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .phase     (phase),
    .stat      (stat),
    .chars     (chars),
    .tokens    (tokens)
  );

endmodule

`default_nettype wire
